// ===== src/dema_pkg.sv =====
package dema_pkg;

   // Frame geometry
   localparam int BIN_COUNT = 1024;
   localparam int IDX_W     = $clog2(BIN_COUNT);

   // Sample and coefficient formats
   localparam int SAMPLE_W = 16;              // signed Q8.8
   localparam int ALPHA_W  = 17;              // unsigned Q1.16, 1.0 = 65536
   localparam int FRAC_W   = 16;
   localparam int DIFF_W   = SAMPLE_W + 1;
   localparam int PROD_W   = DIFF_W + ALPHA_W + 1;
   localparam int SUM_W    = SAMPLE_W + 2;

   localparam logic [ALPHA_W-1:0] ALPHA_MIN           = 17'd3277;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE           = 17'd65536;
   localparam logic [ALPHA_W-1:0] TRACE_ALPHA_RESET   = 17'd26214;
   localparam logic [ALPHA_W-1:0] WATERFALL_ALPHA_RESET = 17'd9830;

   // CSR map
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_TRACE_ALPHA     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_WATERFALL_ALPHA = 1'b1;

   // Input command codes, carried on req_tuser
   localparam logic CMD_BIN     = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   // Stage controls from the sequencer to each smoothing lane
   typedef struct packed {
      logic             rd_en;     // sample word accepted, read its bin
      logic [IDX_W-1:0] rd_addr;
      logic             ld2;       // stage 1 -> stage 2
      logic             ld3;       // stage 2 -> stage 3
      logic             wr_en;     // stage 3 retires, write back
      logic [IDX_W-1:0] wr_addr;
   } dema_lane_ctl_type;

endpackage

// ===== src/dema_lane.sv =====
module dema_lane import dema_pkg::*; (
   input  logic                       clock,
   input  dema_lane_ctl_type          ctl,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic                       primed,
   input  logic        [ALPHA_W-1:0]  alpha,
   output logic signed [SAMPLE_W-1:0] result
);

   logic signed [SAMPLE_W-1:0] store_mem [BIN_COUNT];

   logic signed [SAMPLE_W-1:0] rd_ff;
   logic signed [SAMPLE_W-1:0] x1_ff;
   logic                       primed1_ff;
   logic signed [DIFF_W-1:0]   diff2_ff;
   logic signed [SAMPLE_W-1:0] y2_ff;
   logic signed [PROD_W-1:0]   prod3_ff;
   logic signed [SAMPLE_W-1:0] y3_ff;

   logic signed [SAMPLE_W-1:0] y1;
   logic signed [DIFF_W-1:0]   diff2_in;
   logic signed [PROD_W-1:0]   diff_ext;
   logic signed [PROD_W-1:0]   alpha_ext;
   logic signed [PROD_W-1:0]   prod3_in;
   logic signed [PROD_W-1:0]   rounded;
   logic signed [PROD_W-1:0]   delta_full;
   logic signed [SUM_W-1:0]    sum;

   // stage 1: stored value, or the sample itself on an unprimed frame
   assign y1       = primed1_ff ? rd_ff : x1_ff;
   assign diff2_in = DIFF_W'(x1_ff) - DIFF_W'(y1);

   // stage 2: scale by alpha
   assign diff_ext  = PROD_W'(diff2_ff);
   assign alpha_ext = signed'(PROD_W'(alpha));
   assign prod3_in  = diff_ext * alpha_ext;

   // stage 3: round half up, add, saturate
   assign rounded    = prod3_ff + signed'(PROD_W'(1 << (FRAC_W - 1)));
   assign delta_full = rounded >>> FRAC_W;
   assign sum        = SUM_W'(y3_ff) + delta_full[SUM_W-1:0];

   always_comb begin
      if (sum > SUM_W'(32767)) begin
         result = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (sum < -SUM_W'(32768)) begin
         result = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         result = sum[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_mem[ctl.wr_addr] <= result;
      end
      if (ctl.rd_en) begin
         rd_ff      <= store_mem[ctl.rd_addr];
         x1_ff      <= sample;
         primed1_ff <= primed;
      end
      if (ctl.ld2) begin
         diff2_ff <= diff2_in;
         y2_ff    <= y1;
      end
      if (ctl.ld3) begin
         prod3_ff <= prod3_in;
         y3_ff    <= y2_ff;
      end
   end

endmodule

// ===== src/dual_ema_spectrum_smoother.sv =====
// Dual per-bin exponential moving average for spectrum frames. Bins stream in
// one word per cycle unless rsp_tready or a hazard stalls the input, in bin
// order, with req_tlast on the last bin of a frame; each bin yields one result
// word carrying a trace value and a waterfall value, each updated as
// y += round(alpha * (x - y)) with its own Q1.16 alpha. On the first frame
// after reset or after a restart word (req_tuser = 1), both stores load the
// input directly; a restart returns no word. A frame also ends after
// BIN_COUNT bins. Each accepted word passes the three lane stages and the
// output register before rsp_tvalid rises. Each bin is a read-modify-write of
// its store entry through a three-stage datapath (read/difference, multiply,
// round/saturate), so a bin whose previous update is still in flight waits
// until it is written back: only frames shorter than four bins see this. The
// stores need no clearing pass after reset. Alpha CSR writes are clamped to
// 0.05..1.0 and must be issued only while the block is idle.
module dual_ema_spectrum_smoother import dema_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,   // [15:0] bin_power
   input  logic                  req_tuser,   // [0] command (1 = restart)
   input  logic                  req_tlast,   // frame_end
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [2*SAMPLE_W-1:0] rsp_tdata,   // [15:0] trace_value, [31:16] waterfall_value
   output logic                  rsp_tlast,   // last_of_frame
   // CSR write port
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [ALPHA_W-1:0]    csr_wdata
);

   function automatic logic [ALPHA_W-1:0] clamp_alpha(input logic [ALPHA_W-1:0] v);
      logic [ALPHA_W-1:0] r;
      begin
         if (v < ALPHA_MIN) begin
            r = ALPHA_MIN;
         end else if (v > ALPHA_ONE) begin
            r = ALPHA_ONE;
         end else begin
            r = v;
         end
         return r;
      end
   endfunction

   // CSRs
   logic [ALPHA_W-1:0] trace_alpha_ff, trace_alpha_in;
   logic [ALPHA_W-1:0] wf_alpha_ff, wf_alpha_in;

   // frame tracking
   logic [IDX_W-1:0] bin_cnt_ff, bin_cnt_in;
   logic             primed_ff, primed_in;

   // pipeline valid bits and tags
   logic             v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic [IDX_W-1:0] idx1_ff, idx2_ff, idx3_ff;
   logic             last1_ff, last2_ff, last3_ff;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]   rsp_trace_ff, rsp_wf_ff;
   logic                  rsp_last_ff;

   logic rdy0, rdy1, rdy2, rdy3;
   logic hazard;
   logic accept;
   logic sample_acc;
   logic frame_done;

   dema_lane_ctl_type          lane_ctl;
   logic signed [SAMPLE_W-1:0] trace_res;
   logic signed [SAMPLE_W-1:0] wf_res;

   // Each stage moves when the one after it is empty or moving.
   assign rdy3 = !rsp_valid_ff || rsp_tready;
   assign rdy2 = !v3_ff || rdy3;
   assign rdy1 = !v2_ff || rdy2;
   assign rdy0 = !v1_ff || rdy1;

   // Hold the next bin while an earlier update of the same entry is in flight.
   assign hazard = (v1_ff && idx1_ff == bin_cnt_ff) ||
                   (v2_ff && idx2_ff == bin_cnt_ff) ||
                   (v3_ff && idx3_ff == bin_cnt_ff);

   assign req_tready = rdy0 && !hazard;
   assign accept     = req_tvalid && req_tready;
   assign sample_acc = accept && (req_tuser == CMD_BIN);
   assign frame_done = req_tlast || (bin_cnt_ff == IDX_W'(BIN_COUNT - 1));

   always_comb begin
      bin_cnt_in = bin_cnt_ff;
      primed_in  = primed_ff;
      if (accept) begin
         if (req_tuser == CMD_RESTART) begin
            bin_cnt_in = '0;
            primed_in  = 1'b0;
         end else if (frame_done) begin
            bin_cnt_in = '0;
            primed_in  = 1'b1;
         end else begin
            bin_cnt_in = bin_cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      trace_alpha_in = trace_alpha_ff;
      wf_alpha_in    = wf_alpha_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_TRACE_ALPHA:     trace_alpha_in = clamp_alpha(csr_wdata);
            REG_WATERFALL_ALPHA: wf_alpha_in    = clamp_alpha(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   assign v1_in = rdy0 ? sample_acc : v1_ff;
   assign v2_in = rdy1 ? v1_ff : v2_ff;
   assign v3_in = rdy2 ? v2_ff : v3_ff;
   assign rsp_valid_in = rdy3 ? v3_ff : rsp_valid_ff;

   always_comb begin
      lane_ctl.rd_en   = sample_acc;
      lane_ctl.rd_addr = bin_cnt_ff;
      lane_ctl.ld2     = rdy1 && v1_ff;
      lane_ctl.ld3     = rdy2 && v2_ff;
      lane_ctl.wr_en   = rdy3 && v3_ff;
      lane_ctl.wr_addr = idx3_ff;
   end

   dema_lane u_trace_lane (
      .clock  (clock),
      .ctl    (lane_ctl),
      .sample (signed'(req_tdata)),
      .primed (primed_ff),
      .alpha  (trace_alpha_ff),
      .result (trace_res)
   );

   dema_lane u_wf_lane (
      .clock  (clock),
      .ctl    (lane_ctl),
      .sample (signed'(req_tdata)),
      .primed (primed_ff),
      .alpha  (wf_alpha_ff),
      .result (wf_res)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         trace_alpha_ff <= TRACE_ALPHA_RESET;
         wf_alpha_ff    <= WATERFALL_ALPHA_RESET;
         bin_cnt_ff     <= '0;
         primed_ff      <= 1'b0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         trace_alpha_ff <= trace_alpha_in;
         wf_alpha_ff    <= wf_alpha_in;
         bin_cnt_ff     <= bin_cnt_in;
         primed_ff      <= primed_in;
         v1_ff          <= v1_in;
         v2_ff          <= v2_in;
         v3_ff          <= v3_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // tags and result payload
   always_ff @(posedge clock) begin
      if (sample_acc) begin
         idx1_ff  <= bin_cnt_ff;
         last1_ff <= req_tlast;
      end
      if (lane_ctl.ld2) begin
         idx2_ff  <= idx1_ff;
         last2_ff <= last1_ff;
      end
      if (lane_ctl.ld3) begin
         idx3_ff  <= idx2_ff;
         last3_ff <= last2_ff;
      end
      if (lane_ctl.wr_en) begin
         rsp_trace_ff <= trace_res;
         rsp_wf_ff    <= wf_res;
         rsp_last_ff  <= last3_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_wf_ff, rsp_trace_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // bins in flight are always distinct entries
   a_idx_12: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff) |-> (idx1_ff != idx2_ff))
      else $error("stage 1 and 2 hold the same bin");
   a_idx_13: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v3_ff) |-> (idx1_ff != idx3_ff))
      else $error("stage 1 and 3 hold the same bin");
   a_idx_23: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && v3_ff) |-> (idx2_ff != idx3_ff))
      else $error("stage 2 and 3 hold the same bin");
   // a write-back always lands in the output register
   a_retire: assert property (@(posedge clock) disable iff (reset)
      lane_ctl.wr_en |=> rsp_valid_ff)
      else $error("retired bin produced no result word");
`endif

endmodule
